// ===== design/bst_pkg.sv =====
// Shared types and fixed field widths for the bounded set table.
package bst_pkg;

    localparam int OP_W   = 2;
    localparam int DATA_W = 32;
    localparam int SIZE_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_REM_RD = 5'b00100,
        ST_REM_WR = 5'b01000,
        ST_FIN    = 5'b10000
    } state_t;

endpackage

// ===== design/bst_store.sv =====
// Entry memory with one registered read port, one write port and the key comparator.
module bst_store #(
    parameter int DEPTH = 16,
    parameter int KEY_W = 32,
    parameter int IDX_W = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [KEY_W-1:0] wr_data,
    input  logic [KEY_W-1:0] key,
    output logic [KEY_W-1:0] rd_data,
    output logic [IDX_W-1:0] rd_idx,
    output logic             rd_vld,
    output logic             rd_hit
);

    logic [KEY_W-1:0] mem [DEPTH];
    logic [KEY_W-1:0] rd_data_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_idx_reg  <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= rd_en;
        end
    end

    assign rd_data = rd_data_reg;
    assign rd_idx  = rd_idx_reg;
    assign rd_vld  = rd_vld_reg;
    assign rd_hit  = (rd_data_reg == key);

endmodule

// ===== design/bounded_set_table.sv =====
// Top level of the bounded set table: sequencer, count and result register.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid / in_ready | op, entry_value
//   out     | output    | out_valid/out_ready | ok, match_count, set_size, is_empty
//
// An add or query scans every held entry between accept and the result beat;
// the single memory read port and comparator visit one entry per cycle. A remove
// that hits then reads the last entry and writes it into the freed slot. A clear
// goes straight from accept to the final step without a scan.
// Reset empties the table at once; stored values are not cleared.
// The block takes no new beat until the previous result is in the output
// register, and it waits in its final step while that register is full and not taken.
module bounded_set_table #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bst_pkg::OP_W-1:0]      op,
    input  logic [bst_pkg::DATA_W-1:0]    entry_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          ok,
    output logic [bst_pkg::SIZE_W-1:0]    match_count,
    output logic [bst_pkg::SIZE_W-1:0]    set_size,
    output logic                          is_empty
);

    localparam int KEY_W = (VALUE_WIDTH < bst_pkg::DATA_W) ? VALUE_WIDTH : bst_pkg::DATA_W;
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int OUT_W = bst_pkg::SIZE_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    bst_pkg::state_t           state_reg, state_next;
    bst_pkg::op_t              op_reg, op_next;
    logic [KEY_W-1:0]          key_reg, key_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [CNT_W-1:0]          scan_reg, scan_next;
    logic [CNT_W-1:0]          hits_reg, hits_next;
    logic                      found_reg, found_next;
    logic [IDX_W-1:0]          found_idx_reg, found_idx_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      ok_reg, ok_next;
    logic [OUT_W-1:0]          match_reg, match_next;
    logic [OUT_W-1:0]          size_reg, size_next;
    logic                      empty_reg, empty_next;

    logic                      rd_en, wr_en, rd_vld, rd_hit;
    logic [IDX_W-1:0]          rd_addr, wr_addr, rd_idx;
    logic [KEY_W-1:0]          wr_data, rd_data;

    logic                      issue, hit_now, out_free, add_ok;
    logic [CNT_W-1:0]          count_m1;
    logic [OUT_W+CNT_W-1:0]    size_ext, hits_ext;

    bst_store #(
        .DEPTH (CAPACITY),
        .KEY_W (KEY_W),
        .IDX_W (IDX_W)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .key     (key_reg),
        .rd_data (rd_data),
        .rd_idx  (rd_idx),
        .rd_vld  (rd_vld),
        .rd_hit  (rd_hit)
    );

    assign issue    = (state_reg == bst_pkg::ST_SCAN) && (scan_reg < count_reg);
    assign hit_now  = (state_reg == bst_pkg::ST_SCAN) && rd_vld && rd_hit;
    assign out_free = !out_valid_reg || out_ready;
    assign add_ok   = (count_reg < CAP_CNT) && !found_reg;
    assign count_m1 = count_reg - 1'b1;

    assign rd_en   = issue || (state_reg == bst_pkg::ST_REM_RD);
    assign rd_addr = (state_reg == bst_pkg::ST_REM_RD) ? count_m1[IDX_W-1:0]
                                                       : scan_reg[IDX_W-1:0];

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = found_idx_reg;
        wr_data = rd_data;
        if (state_reg == bst_pkg::ST_REM_WR)
        begin
            wr_en = 1'b1;
        end
        else if ((state_reg == bst_pkg::ST_FIN) && out_free &&
                 (op_reg == bst_pkg::OP_ADD) && add_ok)
        begin
            wr_en   = 1'b1;
            wr_addr = count_reg[IDX_W-1:0];
            wr_data = key_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        hits_next      = hits_reg;
        found_next     = found_reg;
        found_idx_next = found_idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ok_next        = ok_reg;
        match_next     = match_reg;
        size_next      = size_reg;
        empty_next     = empty_reg;
        size_ext       = '0;
        hits_ext       = '0;

        unique case (state_reg)
            bst_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = bst_pkg::op_t'(op);
                    key_next   = entry_value[KEY_W-1:0];
                    scan_next  = '0;
                    hits_next  = '0;
                    found_next = 1'b0;
                    if (bst_pkg::op_t'(op) == bst_pkg::OP_CLEAR)
                    begin
                        state_next = bst_pkg::ST_FIN;
                    end
                    else
                    begin
                        state_next = bst_pkg::ST_SCAN;
                    end
                end
            end
            bst_pkg::ST_SCAN:
            begin
                if (issue)
                begin
                    scan_next = scan_reg + 1'b1;
                end
                if (hit_now)
                begin
                    hits_next = hits_reg + 1'b1;
                    if (!found_reg)
                    begin
                        found_next     = 1'b1;
                        found_idx_next = rd_idx;
                    end
                end
                if (!issue)
                begin
                    if ((op_reg == bst_pkg::OP_REMOVE) && found_next)
                    begin
                        state_next = bst_pkg::ST_REM_RD;
                    end
                    else
                    begin
                        state_next = bst_pkg::ST_FIN;
                    end
                end
            end
            bst_pkg::ST_REM_RD:
            begin
                state_next = bst_pkg::ST_REM_WR;
            end
            bst_pkg::ST_REM_WR:
            begin
                state_next = bst_pkg::ST_FIN;
            end
            bst_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    unique case (op_reg)
                        bst_pkg::OP_ADD:
                        begin
                            ok_next = add_ok;
                            if (add_ok)
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        bst_pkg::OP_REMOVE:
                        begin
                            ok_next = found_reg;
                            if (found_reg)
                            begin
                                count_next = count_m1;
                            end
                        end
                        bst_pkg::OP_QUERY:
                        begin
                            ok_next = (hits_reg != '0);
                        end
                        bst_pkg::OP_CLEAR:
                        begin
                            ok_next    = 1'b1;
                            count_next = '0;
                        end
                        default:
                        begin
                            ok_next = 1'b0;
                        end
                    endcase
                    size_ext       = {{OUT_W{1'b0}}, count_next};
                    hits_ext       = {{OUT_W{1'b0}}, hits_reg};
                    size_next      = size_ext[OUT_W-1:0];
                    match_next     = (op_reg == bst_pkg::OP_QUERY) ? hits_ext[OUT_W-1:0]
                                                                   : '0;
                    empty_next     = (count_next == '0);
                    out_valid_next = 1'b1;
                    state_next     = bst_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bst_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bst_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        scan_reg      <= scan_next;
        hits_reg      <= hits_next;
        found_reg     <= found_next;
        found_idx_reg <= found_idx_next;
        ok_reg        <= ok_next;
        match_reg     <= match_next;
        size_reg      <= size_next;
        empty_reg     <= empty_next;
    end

    assign in_ready    = (state_reg == bst_pkg::ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign ok          = ok_reg;
    assign match_count = match_reg;
    assign set_size    = size_reg;
    assign is_empty    = empty_reg;

endmodule

// ===== design/bst_checker.sv =====
// Port-level checker for the bounded set table and its bind to the top level.
module bst_checker #(
    parameter int CAPACITY = 16
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic                       ok,
    input logic [bst_pkg::SIZE_W-1:0] match_count,
    input logic [bst_pkg::SIZE_W-1:0] set_size,
    input logic                       is_empty
);

    localparam logic [bst_pkg::SIZE_W-1:0] CAP_SIZE = bst_pkg::SIZE_W'(CAPACITY);

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted again while an operation is in progress");

    a_empty_matches_size: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (CAPACITY >= 32) || (is_empty == (set_size == '0)))
        else $error("is_empty disagrees with set_size");

    a_empty_no_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_empty |-> match_count == '0)
        else $error("matches reported on an empty table");

    a_matches_imply_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (match_count != '0) |-> ok)
        else $error("matches reported without ok");

    a_size_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (CAPACITY >= 32) || (set_size <= CAP_SIZE))
        else $error("set_size exceeds capacity");

endmodule

bind bounded_set_table bst_checker #(
    .CAPACITY (CAPACITY)
) u_bst_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .ok          (ok),
    .match_count (match_count),
    .set_size    (set_size),
    .is_empty    (is_empty)
);
